### rtl/asef_pkg.sv
// ----------------------------------------------------------------------------
// asef_pkg
// Shared constants, types and field helpers for the ADC scan EMA filter.
// ----------------------------------------------------------------------------
`default_nettype none

package asef_pkg;

  localparam int SLOTS    = 8;   // scan slots in hardware (1..8)
  localparam int CHANNELS = 18;  // filtered channels (1..32)

  localparam int FIELD_W         = 5;
  localparam int SLOT_REG_W      = 40;
  localparam int SLOT_REG_FIELDS = SLOT_REG_W / FIELD_W;
  localparam int PIN_REG_W       = 45;
  localparam int PINS_PER_REG    = PIN_REG_W / FIELD_W;
  localparam int COUNT_W         = 4;
  localparam int SAMPLE_W        = 12;
  localparam int CH_W            = 5;
  localparam int ACC_W           = 31;
  localparam int SCALE_SHIFT     = 19;

  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ACC_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = PIN_REG_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLOT_COUNT     = 3'd0,
    CFG_SLOT_CHANNELS  = 3'd1,
    CFG_SLOT_LEVELS    = 3'd2,
    CFG_PIN_SHIFT_LOW  = 3'd3,
    CFG_PIN_SHIFT_HIGH = 3'd4
  } cfg_index_t;

  localparam logic [SLOT_REG_W-1:0] SLOT_LEVELS_RST = {SLOT_REG_FIELDS{5'd9}};
  localparam logic [PIN_REG_W-1:0]  PIN_SHIFT_RST   = {PINS_PER_REG{5'd16}};

  typedef struct packed {
    logic [COUNT_W-1:0]    slot_count;
    logic [SLOT_REG_W-1:0] slot_channels;
    logic [SLOT_REG_W-1:0] slot_levels;
    logic [PIN_REG_W-1:0]  pin_shift_low;
    logic [PIN_REG_W-1:0]  pin_shift_high;
  } cfg_t;

  // Five-bit field of a slot register; slots past the register read as zero.
  function automatic logic [FIELD_W-1:0] slot_field(input logic [SLOT_REG_W-1:0] r,
                                                    input logic [SLOT_W-1:0] idx);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int i = 0; i < SLOT_REG_FIELDS; i++) begin
      if (int'(idx) == i) begin
        f = r[FIELD_W*i +: FIELD_W];
      end
    end
    return f;
  endfunction

  // Read shift for a pin; pins without a field shift by zero.
  function automatic logic [FIELD_W-1:0] pin_shift(input cfg_t c,
                                                   input logic [CH_W-1:0] pin);
    logic [FIELD_W-1:0] f;
    f = '0;
    for (int i = 0; i < PINS_PER_REG; i++) begin
      if (int'(pin) == i) begin
        f = c.pin_shift_low[FIELD_W*i +: FIELD_W];
      end
      if (int'(pin) == i + PINS_PER_REG) begin
        f = c.pin_shift_high[FIELD_W*i +: FIELD_W];
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

### rtl/asef_cfg.sv
// ----------------------------------------------------------------------------
// asef_cfg
// Configuration register file for the scan and filter settings.
// ----------------------------------------------------------------------------
`default_nettype none

module asef_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [asef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [asef_pkg::CFG_DATA_W-1:0]   cfg_data,
  output asef_pkg::cfg_t                         cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count     <= '0;
      cfg.slot_channels  <= '0;
      cfg.slot_levels    <= asef_pkg::SLOT_LEVELS_RST;
      cfg.pin_shift_low  <= asef_pkg::PIN_SHIFT_RST;
      cfg.pin_shift_high <= asef_pkg::PIN_SHIFT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        asef_pkg::CFG_SLOT_COUNT: begin
          cfg.slot_count <= cfg_data[asef_pkg::COUNT_W-1:0];
        end
        asef_pkg::CFG_SLOT_CHANNELS: begin
          cfg.slot_channels <= cfg_data[asef_pkg::SLOT_REG_W-1:0];
        end
        asef_pkg::CFG_SLOT_LEVELS: begin
          cfg.slot_levels <= cfg_data[asef_pkg::SLOT_REG_W-1:0];
        end
        asef_pkg::CFG_PIN_SHIFT_LOW: begin
          cfg.pin_shift_low <= cfg_data[asef_pkg::PIN_REG_W-1:0];
        end
        asef_pkg::CFG_PIN_SHIFT_HIGH: begin
          cfg.pin_shift_high <= cfg_data[asef_pkg::PIN_REG_W-1:0];
        end
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/asef_filter.sv
// ----------------------------------------------------------------------------
// asef_filter
// Scan position, per-channel accumulators and the update/read path.
// ----------------------------------------------------------------------------
`default_nettype none

module asef_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire asef_pkg::cfg_t                 cfg,
  input  wire logic                           step,
  input  wire logic                           action,
  input  wire logic [asef_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic [asef_pkg::CH_W-1:0]      read_channel,
  output logic [asef_pkg::CH_W-1:0]           next_channel,
  output logic [asef_pkg::ACC_W-1:0]          value
);

  logic [asef_pkg::ACC_W-1:0]  acc [asef_pkg::CHANNELS];
  logic [asef_pkg::SLOT_W-1:0] pos;
  logic [asef_pkg::SLOT_W-1:0] pos_next;

  logic [asef_pkg::COUNT_W-1:0]   count_eff;
  logic [asef_pkg::COUNT_W-1:0]   pos_inc;
  logic [asef_pkg::CH_W-1:0]      slot_ch;
  logic [asef_pkg::FIELD_W-1:0]   level;
  logic [asef_pkg::CH_W-1:0]      addr;
  logic                           addr_ok;
  logic [asef_pkg::ACC_W-1:0]     acc_cur;
  logic [asef_pkg::ACC_W-1:0]     scaled;
  logic signed [asef_pkg::ACC_W:0] diff;
  logic signed [asef_pkg::ACC_W:0] delta;
  logic signed [asef_pkg::ACC_W:0] acc_sum;
  logic [asef_pkg::FIELD_W-1:0]   rd_shift;

  always_comb begin
    if (cfg.slot_count > asef_pkg::COUNT_W'(asef_pkg::SLOTS)) begin
      count_eff = asef_pkg::COUNT_W'(asef_pkg::SLOTS);
    end else begin
      count_eff = cfg.slot_count;
    end
    pos_inc = asef_pkg::COUNT_W'(pos) + asef_pkg::COUNT_W'(1);
    // wrap at the count; a count of zero or one holds slot 0
    if (pos_inc >= count_eff) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[asef_pkg::SLOT_W-1:0];
    end

    slot_ch = asef_pkg::slot_field(cfg.slot_channels, pos);
    level   = asef_pkg::slot_field(cfg.slot_levels, pos);

    addr    = action ? read_channel : slot_ch;
    addr_ok = (int'(addr) < asef_pkg::CHANNELS);
    acc_cur = '0;
    for (int i = 0; i < asef_pkg::CHANNELS; i++) begin
      if (int'(addr) == i) begin
        acc_cur = acc[i];
      end
    end

    scaled  = asef_pkg::ACC_W'(sample) << asef_pkg::SCALE_SHIFT;
    diff    = $signed({1'b0, scaled}) - $signed({1'b0, acc_cur});
    delta   = diff >>> level;
    acc_sum = $signed({1'b0, acc_cur}) + delta;

    rd_shift = asef_pkg::pin_shift(cfg, read_channel);
    if (action && addr_ok) begin
      value = acc_cur >> rd_shift;
    end else begin
      value = '0;
    end

    next_channel = asef_pkg::slot_field(cfg.slot_channels, action ? pos : pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int i = 0; i < asef_pkg::CHANNELS; i++) begin
        acc[i] <= '0;
      end
    end else if (step && !action) begin
      pos <= pos_next;
      if (addr_ok) begin
        acc[addr[asef_pkg::ACC_IDX_W-1:0]] <= acc_sum[asef_pkg::ACC_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/adc_scan_channel_ema_filter.sv
// ----------------------------------------------------------------------------
// adc_scan_channel_ema_filter
// Round-robin ADC scan with a shift-based low-pass filter per channel.
// ----------------------------------------------------------------------------
// Each input beat is either a conversion sample (tuser = 0) for the channel in
// the current scan slot, or a read of one channel's filtered value (tuser = 1).
// Every beat gives one output beat with the channel to convert next and, on a
// read, the accumulator shifted right by that pin's output shift. A beat is
// registered at the input, handled combinationally by the filter datapath, and
// held in an output register, so the block takes one beat per cycle while the
// output is not stalled; the result passes through the input register and then
// the output register before it is presented.
// Configuration writes are expected only while the block is idle; unmapped
// register indexes are ignored.
`default_nettype none

module adc_scan_channel_ema_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [asef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [asef_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [23:0]                       s_tdata,  // sample[11:0], read_channel[16:12]
  input  wire logic                              s_tuser,  // action
  // output stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [39:0]                            m_tdata   // next_channel[4:0], value[35:5]
);

  asef_pkg::cfg_t cfg;

  logic                          in_valid;
  logic                          in_action;
  logic [asef_pkg::SAMPLE_W-1:0] in_sample;
  logic [asef_pkg::CH_W-1:0]     in_read_channel;
  logic                          step;
  logic [asef_pkg::CH_W-1:0]     res_channel;
  logic [asef_pkg::ACC_W-1:0]    res_value;
  logic [asef_pkg::CH_W-1:0]     out_channel;
  logic [asef_pkg::ACC_W-1:0]    out_value;

  asef_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // advance the held beat when the output register is free or draining
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action       <= s_tuser;
      in_sample       <= s_tdata[11:0];
      in_read_channel <= s_tdata[16:12];
    end
  end

  asef_filter u_filter (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (step),
    .action       (in_action),
    .sample       (in_sample),
    .read_channel (in_read_channel),
    .next_channel (res_channel),
    .value        (res_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_channel <= res_channel;
      out_value   <= res_value;
    end
  end

  assign m_tdata = {4'b0, out_value, out_channel};

endmodule

`default_nettype wire
